// ===== hdl/rpuf_pkg.sv =====
package rpuf_pkg;

    localparam int NODES       = 1024;
    localparam int LEVELS      = 11;
    localparam int NODE_W      = 11;
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int STACK_DEPTH = 2 * LEVELS + 4;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int PAR_DEPTH   = LEVELS << NODE_W;
    localparam int PAR_AW      = $clog2(PAR_DEPTH);
    localparam int MM_DEPTH    = 1 << NODE_W;

    localparam logic [NODE_W-1:0] NODES_C = NODE_W'(NODES);

    // result status codes
    localparam logic [1:0] ST_QUERY  = 2'd0;
    localparam logic [1:0] ST_MERGED = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // item function codes
    localparam logic FN_MERGE = 1'b0;
    localparam logic FN_QUERY = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        logic [LVL_W-1:0]  k;
    } push_t;

    typedef struct packed {
        logic load;
        logic push2;
        logic pop;
    } stk_ctl_t;

    // index of the highest set bit, zero for zero
    function automatic logic [LVL_W-1:0] msb_index(input logic [NODE_W-1:0] x);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < NODE_W; i++)
        begin
            if (x[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/rpuf_if.sv =====
interface rpuf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [rpuf_pkg::NODE_W-1:0] left_start;
    logic [rpuf_pkg::NODE_W-1:0] right_start;
    logic [rpuf_pkg::NODE_W-1:0] span_length;
    logic [rpuf_pkg::NODE_W-1:0] query_node;

    modport source (output valid, func, left_start, right_start, span_length, query_node,
                    input ready);
    modport sink   (input valid, func, left_start, right_start, span_length, query_node,
                    output ready);
endinterface

interface rpuf_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [rpuf_pkg::NODE_W-1:0] comp_min;
    logic [rpuf_pkg::NODE_W-1:0] comp_max;

    modport source (output valid, status, comp_min, comp_max, input ready);
    modport sink   (input valid, status, comp_min, comp_max, output ready);
endinterface

// ===== hdl/rpuf_ram.sv =====
module rpuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/rpuf_stack.sv =====
module rpuf_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  rpuf_pkg::stk_ctl_t ctl,
    input  rpuf_pkg::push_t    load_entry,
    input  rpuf_pkg::push_t    push_hi,
    input  rpuf_pkg::push_t    push_lo,
    output rpuf_pkg::push_t    top,
    output logic               empty
);
    import rpuf_pkg::*;

    push_t           entry_reg [STACK_DEPTH];
    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] sp_next;
    logic [SP_W-1:0] top_idx;
    logic [SP_W-1:0] sp_inc;

    assign top_idx = sp_reg - SP_W'(1);
    assign sp_inc  = sp_reg + SP_W'(1);
    assign top     = entry_reg[top_idx];
    assign empty   = (sp_reg == '0);

    // track depth; drop pushes past the top
    always_comb
    begin
        sp_next = sp_reg;
        if (ctl.load)
        begin
            sp_next = SP_W'(1);
        end
        else if (ctl.pop && !empty)
        begin
            sp_next = top_idx;
        end
        else if (ctl.push2)
        begin
            if (sp_reg < SP_W'(STACK_DEPTH - 1))
            begin
                sp_next = sp_reg + SP_W'(2);
            end
            else if (sp_reg < SP_W'(STACK_DEPTH))
            begin
                sp_next = sp_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    // store entries
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg[0] <= load_entry;
        end
        else if (ctl.push2)
        begin
            if (sp_reg < SP_W'(STACK_DEPTH))
            begin
                entry_reg[sp_reg] <= push_hi;
            end
            if (sp_reg < SP_W'(STACK_DEPTH - 1))
            begin
                entry_reg[sp_inc] <= push_lo;
            end
        end
    end

endmodule

// ===== hdl/range_pair_union_find_minmax.sv =====
// Query: S_FISS, S_FWAIT per parent hop to the level-0 root, then S_QMM, S_QWAIT.
// Merge: data dependent; each block join on the push-down stack walks two parent
// chains through the single parent memory read port (S_FISS, S_FWAIT per entry
// read), plus S_MMA, S_MMB, S_MMW for a level-0 min/max update. One item at a
// time; the next transaction is taken from the cycle the result is presented.
// Reset: a clearing pass over all LEVELS * 2048 parent entries restores all tables.
module range_pair_union_find_minmax (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rpuf_pkg::NODE_W-1:0] cfg_data,
    rpuf_in_if.sink                     in_ch,
    rpuf_out_if.source                  out_ch
);
    import rpuf_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_FISS  = 4'd4;
    localparam logic [3:0] S_FWAIT = 4'd5;
    localparam logic [3:0] S_JOIN  = 4'd6;
    localparam logic [3:0] S_MMA   = 4'd7;
    localparam logic [3:0] S_MMB   = 4'd8;
    localparam logic [3:0] S_MMW   = 4'd9;
    localparam logic [3:0] S_QMM   = 4'd10;
    localparam logic [3:0] S_QWAIT = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [PAR_AW-1:0] clr_reg;
    logic [NODE_W-1:0] node_count_reg;

    logic              func_reg;
    logic [NODE_W-1:0] lft_reg, rgt_reg, len_reg, qn_reg;
    logic [NODE_W-1:0] u2_reg, v2_reg;
    logic [LVL_W-1:0]  k_reg;
    logic              phase_reg;

    push_t             cur_reg;
    logic [NODE_W-1:0] node_reg, a_reg, b_reg;
    logic              which_reg;
    logic [2*NODE_W-1:0] mma_reg;

    logic [1:0]        res_status_reg;
    logic [NODE_W-1:0] res_min_reg, res_max_reg;
    logic              out_valid_reg;

    logic [NODE_W-1:0] limit;
    logic [NODE_W:0]   end_l, end_r;
    logic [NODE_W-1:0] blk, half;
    logic              bad;
    logic [LVL_W-1:0]  k_of_len;

    logic                par_we, par_re;
    logic [PAR_AW-1:0]   par_waddr, par_raddr;
    logic [NODE_W-1:0]   par_wdata, par_rdata;
    logic                mm_we, mm_re;
    logic [NODE_W-1:0]   mm_waddr, mm_raddr;
    logic [2*NODE_W-1:0] mm_wdata, mm_rdata;
    logic [NODE_W-1:0]   new_min, new_max;

    stk_ctl_t stk_ctl;
    push_t    stk_load, stk_hi, stk_lo, stk_top;
    logic     stk_empty;

    // range check of the held merge
    assign limit    = (node_count_reg > NODES_C) ? NODES_C : node_count_reg;
    assign end_l    = {1'b0, lft_reg} + {1'b0, len_reg} - (NODE_W+1)'(1);
    assign end_r    = {1'b0, rgt_reg} + {1'b0, len_reg} - (NODE_W+1)'(1);
    assign k_of_len = msb_index(len_reg);
    assign blk      = NODE_W'(1) << k_of_len;
    assign bad      = (lft_reg == '0) || (rgt_reg == '0) || (len_reg == '0) ||
                      (end_l > {1'b0, limit}) || (end_r > {1'b0, limit}) ||
                      (32'(k_of_len) >= LEVELS);
    assign half     = NODE_W'(1) << (cur_reg.k - LVL_W'(1));

    // min/max of the two roots being joined
    assign new_min = (mma_reg[2*NODE_W-1:NODE_W] < mm_rdata[2*NODE_W-1:NODE_W]) ?
                     mma_reg[2*NODE_W-1:NODE_W] : mm_rdata[2*NODE_W-1:NODE_W];
    assign new_max = (mma_reg[NODE_W-1:0] > mm_rdata[NODE_W-1:0]) ?
                     mma_reg[NODE_W-1:0] : mm_rdata[NODE_W-1:0];

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;

    // memory and stack controls
    always_comb
    begin
        par_we    = 1'b0;
        par_waddr = PAR_AW'({cur_reg.k, a_reg});
        par_wdata = b_reg;
        par_re    = 1'b0;
        par_raddr = PAR_AW'({(func_reg == FN_QUERY) ? LVL_W'(0) : cur_reg.k, node_reg});
        mm_we     = 1'b0;
        mm_waddr  = b_reg;
        mm_wdata  = {new_min, new_max};
        mm_re     = 1'b0;
        mm_raddr  = a_reg;
        stk_ctl   = '0;
        stk_load  = '{u: lft_reg, v: rgt_reg, k: k_of_len};
        stk_hi    = '{u: cur_reg.u + half, v: cur_reg.v + half, k: cur_reg.k - LVL_W'(1)};
        stk_lo    = '{u: cur_reg.u, v: cur_reg.v, k: cur_reg.k - LVL_W'(1)};
        unique case (state_reg)
            S_CLEAR:
            begin
                par_we    = 1'b1;
                par_waddr = clr_reg;
                par_wdata = clr_reg[NODE_W-1:0];
                mm_we     = (clr_reg < PAR_AW'(MM_DEPTH));
                mm_waddr  = clr_reg[NODE_W-1:0];
                mm_wdata  = {clr_reg[NODE_W-1:0], clr_reg[NODE_W-1:0]};
            end
            S_CHECK:
            begin
                stk_ctl.load = !bad && (func_reg == FN_MERGE);
            end
            S_POP:
            begin
                stk_ctl.pop = 1'b1;
            end
            S_FISS:
            begin
                par_re = 1'b1;
            end
            S_JOIN:
            begin
                par_we        = (a_reg != b_reg);
                stk_ctl.push2 = (a_reg != b_reg) && (cur_reg.k != '0);
            end
            S_MMA:
            begin
                mm_re    = 1'b1;
                mm_raddr = a_reg;
            end
            S_MMB:
            begin
                mm_re    = 1'b1;
                mm_raddr = b_reg;
            end
            S_MMW:
            begin
                mm_we = 1'b1;
            end
            S_QMM:
            begin
                mm_re    = 1'b1;
                mm_raddr = node_reg;
            end
            S_NEXT:
            begin
                stk_load     = '{u: u2_reg, v: v2_reg, k: k_reg};
                stk_ctl.load = stk_empty && (phase_reg == 1'b0);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == PAR_AW'(PAR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (func_reg == FN_QUERY)
                begin
                    state_next = ((qn_reg == '0) || (qn_reg > NODES_C)) ? S_DONE : S_FISS;
                end
                else
                begin
                    state_next = bad ? S_DONE : S_POP;
                end
            end
            S_POP:   state_next = S_FISS;
            S_FISS:  state_next = S_FWAIT;
            S_FWAIT:
            begin
                if (par_rdata == node_reg)
                begin
                    if (func_reg == FN_QUERY)
                    begin
                        state_next = S_QMM;
                    end
                    else if (which_reg)
                    begin
                        state_next = S_JOIN;
                    end
                    else
                    begin
                        state_next = S_FISS;
                    end
                end
                else
                begin
                    state_next = S_FISS;
                end
            end
            S_JOIN:
            begin
                state_next = ((a_reg != b_reg) && (cur_reg.k == '0)) ? S_MMA : S_NEXT;
            end
            S_MMA:   state_next = S_MMB;
            S_MMB:   state_next = S_MMW;
            S_MMW:   state_next = S_NEXT;
            S_QMM:   state_next = S_QWAIT;
            S_QWAIT: state_next = S_DONE;
            S_NEXT:
            begin
                if (!stk_empty || (phase_reg == 1'b0))
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            node_count_reg <= NODE_W'(1024);
            out_valid_reg  <= 1'b0;
            phase_reg      <= 1'b0;
            which_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + PAR_AW'(1);
            end
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            if (state_reg == S_CHECK)
            begin
                phase_reg <= 1'b0;
            end
            else if (state_reg == S_NEXT && stk_empty)
            begin
                phase_reg <= 1'b1;
            end
            if (state_reg == S_POP || state_reg == S_CHECK)
            begin
                which_reg <= 1'b0;
            end
            else if (state_reg == S_FWAIT && par_rdata == node_reg)
            begin
                which_reg <= 1'b1;
            end
            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_DONE && state_next == S_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            func_reg <= in_ch.func;
            lft_reg  <= in_ch.left_start;
            rgt_reg  <= in_ch.right_start;
            len_reg  <= in_ch.span_length;
            qn_reg   <= in_ch.query_node;
            node_reg <= in_ch.query_node;
        end
        if (state_reg == S_CHECK)
        begin
            k_reg          <= k_of_len;
            u2_reg         <= lft_reg + len_reg - blk;
            v2_reg         <= rgt_reg + len_reg - blk;
            res_status_reg <= (func_reg == FN_QUERY) ? ST_QUERY :
                              (bad ? ST_REJECT : ST_MERGED);
            res_min_reg    <= (func_reg == FN_QUERY) ? qn_reg : '0;
            res_max_reg    <= (func_reg == FN_QUERY) ? qn_reg : '0;
        end
        if (state_reg == S_POP)
        begin
            cur_reg  <= stk_top;
            node_reg <= stk_top.u;
        end
        if (state_reg == S_FWAIT)
        begin
            if (par_rdata != node_reg)
            begin
                node_reg <= par_rdata;
            end
            else if (func_reg == FN_MERGE && !which_reg)
            begin
                a_reg    <= node_reg;
                node_reg <= cur_reg.v;
            end
            else
            begin
                b_reg <= node_reg;
            end
        end
        if (state_reg == S_MMB)
        begin
            mma_reg <= mm_rdata;
        end
        if (state_reg == S_QWAIT)
        begin
            res_min_reg <= mm_rdata[2*NODE_W-1:NODE_W];
            res_max_reg <= mm_rdata[NODE_W-1:0];
        end
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            out_ch.status   <= res_status_reg;
            out_ch.comp_min <= res_min_reg;
            out_ch.comp_max <= res_max_reg;
        end
    end

    rpuf_ram #(.WIDTH(NODE_W), .DEPTH(PAR_DEPTH)) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    rpuf_ram #(.WIDTH(2*NODE_W), .DEPTH(MM_DEPTH)) u_minmax (
        .clk   (clk),
        .we    (mm_we),
        .waddr (mm_waddr),
        .wdata (mm_wdata),
        .re    (mm_re),
        .raddr (mm_raddr),
        .rdata (mm_rdata)
    );

    rpuf_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (stk_ctl),
        .load_entry (stk_load),
        .push_hi    (stk_hi),
        .push_lo    (stk_lo),
        .top        (stk_top),
        .empty      (stk_empty)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("ready held after accepted transaction");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result during clearing pass");

    a_merge_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && func_reg == FN_MERGE) |-> (res_status_reg != ST_QUERY))
        else $error("merge ended with query status");

    a_join_writes_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MMW) |-> $past(state_reg == S_MMB, 1))
        else $error("min/max write out of sequence");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import rpuf_pkg::*;

    localparam int CYCLE_LIMIT = 60000000;

    typedef struct {
        logic [1:0]        status;
        logic [NODE_W-1:0] comp_min;
        logic [NODE_W-1:0] comp_max;
    } answer_t;

    typedef struct {
        int u;
        int v;
        int k;
    } block_join_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [NODE_W-1:0] cfg_data;

    rpuf_in_if  in_ch ();
    rpuf_out_if out_ch ();

    range_pair_union_find_minmax u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // shadow of the block state
    int          shadow_parent [LEVELS][NODES+1];
    int          shadow_min [NODES+1];
    int          shadow_max [NODES+1];
    block_join_t join_stack [STACK_DEPTH];
    int          join_sp;
    int          shadow_nodes;

    answer_t pending_answers [$];
    int      errors;
    int      cycles;
    int      n_merged;
    int      n_rejected;
    int      n_queries;
    int      ready_pct;
    int      ready_hold;
    int      gap_pct;

    // clock and run limit
    initial
    begin
        clk    = 1'b0;
        cycles = 0;
        forever
        begin
            #2 clk = ~clk;
            if (clk)
            begin
                cycles++;
                if (cycles > CYCLE_LIMIT)
                begin
                    $display("testbench: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic int uf_find(int node, int lvl);
        while (shadow_parent[lvl][node] != node)
        begin
            shadow_parent[lvl][node] = shadow_parent[lvl][shadow_parent[lvl][node]];
            node = shadow_parent[lvl][node];
        end
        return node;
    endfunction

    function automatic bit uf_join(int u, int v, int lvl);
        int a;
        int b;
        a = uf_find(u, lvl);
        b = uf_find(v, lvl);
        if (a == b)
            return 1'b0;
        if (lvl == 0)
        begin
            if (shadow_max[a] > shadow_max[b])
                shadow_max[b] = shadow_max[a];
            if (shadow_min[a] < shadow_min[b])
                shadow_min[b] = shadow_min[a];
        end
        shadow_parent[lvl][a] = b;
        return 1'b1;
    endfunction

    function automatic void stack_push(int u, int v, int k);
        if (join_sp < STACK_DEPTH)
        begin
            join_stack[join_sp] = '{u, v, k};
            join_sp++;
        end
    endfunction

    // join two blocks and spread the join down to level 0
    function automatic void uf_spread(int u, int v, int k);
        block_join_t e;
        int          half;
        join_sp = 0;
        stack_push(u, v, k);
        while (join_sp > 0)
        begin
            join_sp--;
            e = join_stack[join_sp];
            if (uf_join(e.u, e.v, e.k) && e.k > 0)
            begin
                half = 1 << (e.k - 1);
                stack_push(e.u + half, e.v + half, e.k - 1);
                stack_push(e.u, e.v, e.k - 1);
            end
        end
    endfunction

    function automatic answer_t predict_item(logic fn, int l, int r, int len, int q);
        answer_t a;
        int      lim;
        int      k;
        int      root;
        lim = (shadow_nodes > NODES) ? NODES : shadow_nodes;
        a   = '{ST_QUERY, '0, '0};
        if (fn == FN_MERGE)
        begin
            k = 0;
            while (k < 31 && (len >> (k + 1)) != 0)
                k++;
            if (l == 0 || r == 0 || len == 0 || l + len - 1 > lim ||
                r + len - 1 > lim || k >= LEVELS)
            begin
                a.status = ST_REJECT;
                n_rejected++;
            end
            else
            begin
                uf_spread(l, r, k);
                uf_spread(l + len - (1 << k), r + len - (1 << k), k);
                a.status = ST_MERGED;
                n_merged++;
            end
        end
        else
        begin
            n_queries++;
            if (q == 0 || q > NODES)
            begin
                a.comp_min = NODE_W'(q);
                a.comp_max = NODE_W'(q);
            end
            else
            begin
                root       = uf_find(q, 0);
                a.comp_min = NODE_W'(shadow_min[root]);
                a.comp_max = NODE_W'(shadow_max[root]);
            end
        end
        return a;
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send_item(logic fn, int l, int r, int len, int q);
        int g;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick >= gap_pct)
            g = 0;
        else if (pick < gap_pct * 8 / 10)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(8, 60);
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= fn;
        in_ch.left_start  <= NODE_W'(l);
        in_ch.right_start <= NODE_W'(r);
        in_ch.span_length <= NODE_W'(len);
        in_ch.query_node  <= NODE_W'(q);
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_answers.insert(pending_answers.size(), predict_item(fn, l, r, len, q));
    endtask

    // drop valid and wait until every answer is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_node_count(int val);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= NODE_W'(val);
        @(posedge clk);
        cfg_we       <= 1'b0;
        shadow_nodes = val;
    endtask

    // mostly legal merges and queries, some raw noise
    task automatic random_item();
        int lim;
        int len;
        int pick;
        lim  = (shadow_nodes > NODES) ? NODES : shadow_nodes;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if ($urandom_range(0, 99) < 4)
                len = $urandom_range(1, lim);
            else
                len = $urandom_range(1, (lim < 8) ? lim : 8);
            send_item(FN_MERGE, $urandom_range(1, lim - len + 1),
                      $urandom_range(1, lim - len + 1), len, $urandom_range(0, 2047));
        end
        else if (pick < 63)
        begin
            send_item(FN_MERGE, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
        end
        else if (pick < 93)
        begin
            send_item(FN_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(1, lim));
        end
        else
        begin
            send_item(FN_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
        end
    endtask

    task automatic test_directed();
        ready_pct = 100;
        gap_pct   = 0;
        // queries at reset: out of table, edges
        send_item(FN_QUERY, 0, 0, 0, 0);
        send_item(FN_QUERY, 2047, 2047, 2047, 1);
        send_item(FN_QUERY, 0, 0, 0, 1024);
        send_item(FN_QUERY, 0, 0, 0, 1025);
        send_item(FN_QUERY, 0, 0, 0, 2047);
        // rejected merges: zero fields, past the end
        send_item(FN_MERGE, 0, 1, 1, 0);
        send_item(FN_MERGE, 1, 0, 1, 0);
        send_item(FN_MERGE, 1, 1, 0, 0);
        send_item(FN_MERGE, 1, 2, 1024, 0);
        send_item(FN_MERGE, 2047, 1, 2047, 2047);
        // legal merges, a repeated one, a full-span one
        send_item(FN_MERGE, 1, 1024, 1, 0);
        send_item(FN_MERGE, 1, 1024, 1, 0);
        send_item(FN_QUERY, 0, 0, 0, 1024);
        send_item(FN_MERGE, 3, 10, 5, 0);
        send_item(FN_QUERY, 0, 0, 0, 12);
        send_item(FN_MERGE, 1, 1, 1024, 0);
        send_item(FN_MERGE, 100, 513, 512, 0);
        send_item(FN_QUERY, 0, 0, 0, 700);
        // shrink node_count: later merges checked, lookup stays full
        set_node_count(1);
        send_item(FN_MERGE, 1, 1, 1, 0);
        send_item(FN_MERGE, 1, 2, 1, 0);
        send_item(FN_QUERY, 0, 0, 0, 900);
        set_node_count(2047);
        send_item(FN_MERGE, 1024, 1024, 1, 0);
        send_item(FN_MERGE, 1025, 1, 1, 0);
        set_node_count(1024);
    endtask

    task automatic test_random();
        int sizes [5] = '{16, 64, 300, 1024, 5};
        for (int ph = 0; ph < 5; ph++)
        begin
            set_node_count(sizes[ph]);
            // reset the tables for a fresh dense run every other phase is not possible,
            // so alternate idling styles instead
            ready_pct = (ph % 2 == 0) ? 70 : 100;
            gap_pct   = (ph % 2 == 0) ? 40 : 0;
            for (int i = 0; i < 300; i++)
                random_item();
        end
    endtask

    task automatic test_backpressure();
        set_node_count(128);
        ready_pct  = 100;
        gap_pct    = 0;
        ready_hold = 3000;
        for (int i = 0; i < 60; i++)
            random_item();
        ready_pct = 50;
        gap_pct   = 60;
        for (int i = 0; i < 100; i++)
            random_item();
    endtask

    // receiver with random stalls and occasional long ones
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
            begin
                ready_hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (ready_pct < 100 && $urandom_range(0, 499) == 0)
                    ready_hold = $urandom_range(20, 150);
                out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d min=%0d max=%0d", $time,
                         out_ch.status, out_ch.comp_min, out_ch.comp_max);
            end
            else
            begin
                e = pending_answers.pop_front();
                if (out_ch.status !== e.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             out_ch.status);
                end
                if (out_ch.comp_min !== e.comp_min)
                begin
                    errors++;
                    $display("%0t: comp_min expected %0d actual %0d", $time, e.comp_min,
                             out_ch.comp_min);
                end
                if (out_ch.comp_max !== e.comp_max)
                begin
                    errors++;
                    $display("%0t: comp_max expected %0d actual %0d", $time, e.comp_max,
                             out_ch.comp_max);
                end
            end
        end
    end

    initial
    begin
        errors     = 0;
        n_merged   = 0;
        n_rejected = 0;
        n_queries  = 0;
        ready_pct  = 100;
        ready_hold = 0;
        gap_pct    = 0;
        for (int lv = 0; lv < LEVELS; lv++)
            for (int i = 0; i <= NODES; i++)
                shadow_parent[lv][i] = i;
        for (int i = 0; i <= NODES; i++)
        begin
            shadow_min[i] = i;
            shadow_max[i] = i;
        end
        shadow_nodes = 1024;
        join_sp      = 0;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= FN_MERGE;
        in_ch.left_start  <= '0;
        in_ch.right_start <= '0;
        in_ch.span_length <= '0;
        in_ch.query_node  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();
        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d merges, %0d rejected merges, %0d queries", n_merged,
                 n_rejected, n_queries);
        $display("node_count settings 1 to 2047, random stalls and one long output hold-off");
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
